[sv/nwc_pkg.sv]
// ----------------------------------------------------------------------------
// nwc_pkg
// Shared constants, types and helpers of the normalized window convolution.
// ----------------------------------------------------------------------------
package nwc_pkg;

  localparam int unsigned MAX_KERNEL = 5;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned COEF_BITS  = 12;

  localparam int unsigned COEF_ROWS  = 5;
  localparam int unsigned COEF_REG_W = 60;
  localparam int unsigned CFG_W      = 60;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned KSIZE_W    = 3;
  localparam int unsigned IWIDTH_W   = 11;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned VAL_W      = 25;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 10;

  localparam int unsigned K_W        = $clog2(MAX_KERNEL + 1);
  localparam int unsigned SLOT_W     = $clog2(MAX_KERNEL);
  localparam int unsigned TAPS       = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned MEM_DEPTH  = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);
  localparam int unsigned PROD_W     = COEF_BITS + PIX_W + 1;
  localparam int unsigned ACC_W      = PROD_W + $clog2(TAPS);
  localparam int unsigned WSUM_W     = COEF_BITS + $clog2(TAPS) + 1;
  localparam int unsigned NUM_W      = ACC_W + 1;
  localparam int unsigned DEN_W      = WSUM_W + 1;
  localparam int unsigned CNT_W      = $clog2(NUM_W + 1);
  localparam logic [ROW_W-1:0] ROW_SAT = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_OUTPUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_0    = 3'd3;

  typedef logic [COEF_ROWS-1:0][COEF_REG_W-1:0] coef_rows_t;

  typedef struct packed {
    logic [K_W-1:0]      k;
    logic [IWIDTH_W-1:0] w;
    logic                signed_out;
    coef_rows_t          coef;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic mac;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic win;
    logic last_tap;
    logic div_done;
    logic out_free;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MAC, ST_DIV_INIT, ST_DIV, ST_FINISH
  } state_e;

  function automatic logic signed [COEF_BITS-1:0] coef_at(
    input coef_rows_t rows, input logic [K_W-1:0] i, input logic [K_W-1:0] j);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    if (32'(i) < COEF_ROWS && (32'(j) + 1) * COEF_BITS <= COEF_REG_W)
      c = rows[i[SLOT_W-1:0]][32'(j) * COEF_BITS +: COEF_BITS];
    return c;
  endfunction

endpackage

[sv/nwc_pix_if.sv]
// ----------------------------------------------------------------------------
// nwc_pix_if
// Pixel stream channel: valid/ready handshake with pixel and frame start.
// ----------------------------------------------------------------------------
interface nwc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

[sv/nwc_res_if.sv]
// ----------------------------------------------------------------------------
// nwc_res_if
// Result stream channel: valid/ready handshake with value and centre position.
// ----------------------------------------------------------------------------
interface nwc_res_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] value;
  logic [11:0]        out_row;
  logic [9:0]         out_col;
  modport source (output valid, value, out_row, out_col, input ready);
  modport sink   (input valid, value, out_row, out_col, output ready);
endinterface

[sv/nwc_ctrl.sv]
// ----------------------------------------------------------------------------
// nwc_ctrl
// Sequencer: accept, tap loop, division and result hand-off.
// ----------------------------------------------------------------------------
module nwc_ctrl
  import nwc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.win) state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        state_d   = status_i.last_tap ? ST_DIV_INIT : ST_READ;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_FINISH;
        else                   cmd_o.div_step = 1'b1;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/nwc_datapath.sv]
// ----------------------------------------------------------------------------
// nwc_datapath
// Position counters, line memory, multiply-accumulate, divider, output word.
// ----------------------------------------------------------------------------
module nwc_datapath
  import nwc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [PIX_W-1:0]        pixel_i,
  input  logic                    frame_start_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] value_o,
  output logic [ROW_W-1:0]        out_row_o,
  output logic [COL_W-1:0]        out_col_o
);

  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [SLOT_W-1:0] ring_q;
  logic [COL_W-1:0]  c_cur;
  logic [ROW_W-1:0]  r_cur;
  logic [SLOT_W-1:0] ring_cur;
  logic [COL_W:0]    c_next;
  logic [K_W-1:0]    km1, half;
  logic [SLOT_W:0]   s0_raw;
  logic [SLOT_W-1:0] s0;

  logic [PIX_W-1:0]  mem [MEM_DEPTH];
  logic [PIX_W-1:0]  rd_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic [K_W-1:0]    ti_q, tj_q;
  logic [SLOT_W-1:0] slot_q;
  logic [COL_W-1:0]  colbase_q;
  logic [ROW_W-1:0]  orow_q;
  logic [COL_W-1:0]  ocol_q;

  logic signed [COEF_BITS-1:0] coef;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [WSUM_W-1:0]    wsum_q;

  logic [ACC_W-1:0]  mag;
  logic [WSUM_W-1:0] dsel;
  logic              neg_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [DEN_W:0]    rem_sh;
  logic              qbit;
  logic [CNT_W-1:0]  cnt_q;

  logic [NUM_W-1:0]        tc;
  logic signed [VAL_W-1:0] val;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] value_q;
  logic [ROW_W-1:0]        out_row_q;
  logic [COL_W-1:0]        out_col_q;

  assign km1      = cfg_i.k - K_W'(1);
  assign half     = cfg_i.k >> 1;
  assign c_cur    = frame_start_i ? '0 : col_q;
  assign r_cur    = frame_start_i ? '0 : row_q;
  assign ring_cur = frame_start_i ? '0 : ring_q;
  assign c_next   = {1'b0, c_cur} + (COL_W+1)'(1);
  assign s0_raw   = (SLOT_W+1)'(ring_cur) + (SLOT_W+1)'(MAX_KERNEL) - (SLOT_W+1)'(km1);
  assign s0       = (s0_raw >= (SLOT_W+1)'(MAX_KERNEL))
                  ? SLOT_W'(s0_raw - (SLOT_W+1)'(MAX_KERNEL)) : SLOT_W'(s0_raw);

  assign status_o.win      = (r_cur >= ROW_W'(km1)) && (c_cur >= COL_W'(km1));
  assign status_o.last_tap = (ti_q == km1) && (tj_q == km1);
  assign status_o.div_done = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ring_q <= '0;
    end else if (cmd_i.accept) begin
      if (c_next >= (COL_W+1)'(cfg_i.w)) begin
        col_q  <= '0;
        row_q  <= (r_cur == ROW_SAT) ? r_cur : r_cur + ROW_W'(1);
        ring_q <= (ring_cur == SLOT_W'(MAX_KERNEL - 1)) ? '0 : ring_cur + SLOT_W'(1);
      end else begin
        col_q  <= c_next[COL_W-1:0];
        row_q  <= r_cur;
        ring_q <= ring_cur;
      end
    end
  end

  // line memory
  assign wr_addr = ADDR_W'(ring_cur) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_cur);
  assign rd_addr = ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(colbase_q + COL_W'(tj_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) mem[wr_addr] <= pixel_i;
    if (cmd_i.rd)     rd_q <= mem[rd_addr];
  end

  // tap loop and accumulation
  assign coef = coef_at(cfg_i.coef, ti_q, tj_q);
  assign prod = coef * $signed({1'b0, rd_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ti_q      <= '0;
      tj_q      <= '0;
      slot_q    <= s0;
      colbase_q <= c_cur - COL_W'(km1);
      orow_q    <= r_cur - ROW_W'(half);
      ocol_q    <= c_cur - COL_W'(half);
      acc_q     <= '0;
      wsum_q    <= '0;
    end else if (cmd_i.mac) begin
      acc_q  <= acc_q + ACC_W'(prod);
      wsum_q <= wsum_q + WSUM_W'(coef);
      if (tj_q == km1) begin
        tj_q   <= '0;
        ti_q   <= ti_q + K_W'(1);
        slot_q <= (slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_q + SLOT_W'(1);
      end else begin
        tj_q <= tj_q + K_W'(1);
      end
    end
  end

  // rounding divider: (2|acc| + d) / 2d, one quotient bit per cycle
  assign mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign dsel   = (wsum_q < WSUM_W'(1)) ? WSUM_W'(1) : WSUM_W'(wsum_q);
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= acc_q[ACC_W-1];
      num_q <= {mag, 1'b0} + NUM_W'(dsel);
      den_q <= {dsel, 1'b0};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], qbit};
    end
  end

  // output word
  assign tc = neg_q ? -num_q : num_q;

  always_comb begin
    if (cfg_i.signed_out) begin
      if (!neg_q)
        val = (num_q > NUM_W'({1'b0, {(VAL_W-1){1'b1}}})) ? {1'b0, {(VAL_W-1){1'b1}}}
                                                         : VAL_W'(num_q);
      else
        val = (num_q > NUM_W'({1'b1, {(VAL_W-1){1'b0}}})) ? {1'b1, {(VAL_W-1){1'b0}}}
                                                         : VAL_W'(tc);
    end else begin
      val = VAL_W'(tc[PIX_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              out_valid_q <= 1'b0;
    else if (cmd_i.load_out)  out_valid_q <= 1'b1;
    else if (out_ready_i)     out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      value_q   <= val;
      out_row_q <= orow_q;
      out_col_q <= ocol_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

  a_ring_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_q < SLOT_W'(MAX_KERNEL)) else $error("ring slot out of range");
  a_mac_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac |-> $past(cmd_i.rd)) else $error("accumulate without read");
  a_div_after_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> $past(cmd_i.mac)) else $error("divide without taps");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");

endmodule

[sv/normalized_window_convolution_unit.sv]
// ----------------------------------------------------------------------------
// normalized_window_convolution_unit
// Streaming K x K (3 or 5) normalized convolution over an 8-bit image.
// ----------------------------------------------------------------------------
// pix_i takes one pixel word per handshake in raster order; frame_start marks
// row 0, column 0. res_o gives one word for each pixel that completes a
// window lying fully inside the image, tagged with the window centre.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must do so only while the block is idle, which the block itself does
// not enforce. A pixel without a window leaves the block idle. A pixel with a
// window runs one line memory read and one multiply-accumulate per tap, a
// divider setup step, a bit-serial divider of 27 steps and a check that it is
// done, and a hand-off that loads the result word into an output register; no
// pixel is accepted before that hand-off. The next pixel is accepted while the
// result waits there. If the receiver stalls and a new result is ready, the
// unit holds it and accepts nothing until the output register frees. Reset
// clears the counters and coefficients and sets K = 3, width 1024 and unsigned
// output; line memory content is undefined until written.
// ----------------------------------------------------------------------------
module normalized_window_convolution_unit
  import nwc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  nwc_pix_if.sink              pix_i,
  nwc_res_if.source            res_o
);

  logic [KSIZE_W-1:0]  ksize_q;
  logic [IWIDTH_W-1:0] iwidth_q;
  logic                signed_q;
  coef_rows_t          coef_q;
  logic [KSIZE_W-1:0]  k_odd;
  cfg_t                cfg;
  cmd_t                cmd;
  status_t             status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q  <= KSIZE_W'(3);
      iwidth_q <= IWIDTH_W'(1024);
      signed_q <= 1'b0;
      coef_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KERNEL_SIZE:   ksize_q  <= cfg_data_i[KSIZE_W-1:0];
        CFG_IMAGE_WIDTH:   iwidth_q <= cfg_data_i[IWIDTH_W-1:0];
        CFG_SIGNED_OUTPUT: signed_q <= cfg_data_i[0];
        default:
          if (cfg_idx_i >= CFG_COEF_ROW_0)
            coef_q[cfg_idx_i - CFG_COEF_ROW_0] <= cfg_data_i[COEF_REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    k_odd = (!ksize_q[0] && ksize_q != '0) ? ksize_q - KSIZE_W'(1) : ksize_q;
    if (k_odd < KSIZE_W'(3))                   cfg.k = K_W'(3);
    else if (32'(k_odd) > MAX_KERNEL)          cfg.k = K_W'(MAX_KERNEL);
    else                                       cfg.k = K_W'(k_odd);
    if (iwidth_q == '0)                        cfg.w = IWIDTH_W'(1);
    else if (32'(iwidth_q) > MAX_WIDTH)        cfg.w = IWIDTH_W'(MAX_WIDTH);
    else                                       cfg.w = iwidth_q;
    cfg.signed_out = signed_q;
    cfg.coef       = coef_q;
  end

  nwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nwc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_i       (pix_i.pixel),
    .frame_start_i (pix_i.frame_start),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .value_o       (res_o.value),
    .out_row_o     (res_o.out_row),
    .out_col_o     (res_o.out_col)
  );

endmodule
